/* src/tcmac_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and AES-128 helper functions for the truncated CMAC authenticator.
// Depends on nothing; used by tcmac_aes_enc and the top level.
package tcmac_pkg;

	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned TAG_BYTES = 4;
	localparam int unsigned MAX_PAYLOAD = 8;
	localparam int unsigned NUM_ROUNDS = 10;

	localparam logic [63:0] KEY_HIGH_RESET = 64'h0001020304050607;
	localparam logic [63:0] KEY_LOW_RESET = 64'h08090A0B0C0D0E0F;

	typedef logic [127:0] block_t;
	typedef block_t round_keys_t [NUM_ROUNDS + 1];

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_index_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NUM_ROUNDS] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// Byte i of a block sits in bits 127-8i down to 120-8i.
	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		get_byte = b[127 - 8 * i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t aes_round(input block_t s, input block_t rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		block_t res;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[i + 4 * c] = SBOX[get_byte(s, i + 4 * ((c + i) % 4))];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			res[127 - 8 * i -: 8] = t[i];
		end
		aes_round = res ^ rk;
	endfunction

	function automatic block_t next_round_key(input block_t prev, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = prev[127:96];
		w1 = prev[95:64];
		w2 = prev[63:32];
		w3 = prev[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		next_round_key = {w0, w1, w2, w3};
	endfunction

	// Multiplication by x in GF(2^128) as CMAC subkey generation uses it.
	function automatic block_t double_block(input block_t b);
		double_block = {b[126:0], 1'b0} ^ (b[127] ? 128'h87 : 128'h0);
	endfunction

endpackage

/* src/tcmac_aes_enc.sv */
`timescale 1ns / 1ps
// AES-128 block encryption as one combinational pass over prepared round keys.
// Depends on tcmac_pkg for the round function and types.
module tcmac_aes_enc (
	input  tcmac_pkg::block_t      plain,
	input  tcmac_pkg::round_keys_t rk,
	output tcmac_pkg::block_t      cipher
);

	tcmac_pkg::block_t st [tcmac_pkg::NUM_ROUNDS + 1];

	always_comb begin
		st[0] = plain ^ rk[0];
		for (int r = 1; r <= tcmac_pkg::NUM_ROUNDS; r++) begin
			st[r] = tcmac_pkg::aes_round(st[r - 1], rk[r], r == tcmac_pkg::NUM_ROUNDS);
		end
	end

	assign cipher = st[tcmac_pkg::NUM_ROUNDS];

endmodule

/* src/truncated_cmac_authenticator_unit.sv */
`timescale 1ns / 1ps
// Top level of the truncated AES-128-CMAC frame authenticator.
// Depends on tcmac_pkg and tcmac_aes_enc.

// One frame is accepted per cycle while in_stall is low; the frame is held in an input register,
// encrypted in a single combinational AES pass and captured in the result register, from which
// its result is offered. Round keys and the K2 subkey are held in registers derived from the
// key registers; after a key write, and after reset, the input side stalls while these settle.
// The config port is always ready.
module truncated_cmac_authenticator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] payload,
	input  logic [3:0]  payload_len,
	input  logic [31:0] freshness,
	input  logic [31:0] received_mac,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] computed_mac,
	output logic        mac_match,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_high_q, key_low_q;
	logic [1:0]  cfg_busy_q;
	tcmac_pkg::round_keys_t rk_q, rk_d;
	tcmac_pkg::block_t      k2_q, l_enc;
	logic cfg_write;

	logic        s1_valid;
	logic [63:0] payload_s1;
	logic [3:0]  len_s1;
	logic [31:0] fresh_s1;
	logic [31:0] rmac_s1;
	tcmac_pkg::block_t msg_blk, tag_blk;

	logic out_free, s1_take, in_accept;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// The busy shift register starts full so that the derived keys settle after reset too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= tcmac_pkg::KEY_HIGH_RESET;
			key_low_q  <= tcmac_pkg::KEY_LOW_RESET;
			cfg_busy_q <= 2'b11;
		end else begin
			cfg_busy_q <= {cfg_busy_q[0], cfg_write};
			if (cfg_write) begin
				case (cfg_index)
					tcmac_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
					tcmac_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		rk_d[0] = {key_high_q, key_low_q};
		for (int r = 1; r <= tcmac_pkg::NUM_ROUNDS; r++) begin
			rk_d[r] = tcmac_pkg::next_round_key(rk_d[r - 1], tcmac_pkg::RCON[r - 1]);
		end
	end

	// The subkey pass encrypts the zero block under the keys already held in rk_q.
	tcmac_aes_enc u_subkey_enc (
		.plain  (128'h0),
		.rk     (rk_q),
		.cipher (l_enc)
	);

	always_ff @(posedge clk) begin
		rk_q <= rk_d;
		k2_q <= tcmac_pkg::double_block(tcmac_pkg::double_block(l_enc));
	end

	assign out_free  = !out_valid || !out_stall;
	assign s1_take   = !s1_valid || out_free;
	assign in_stall  = !s1_take || (cfg_busy_q != 2'b00);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_take) begin
			s1_valid <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			payload_s1 <= payload;
			len_s1     <= (payload_len > 4'(tcmac_pkg::MAX_PAYLOAD)) ?
				4'(tcmac_pkg::MAX_PAYLOAD) : payload_len;
			fresh_s1   <= freshness;
			rmac_s1    <= received_mac;
		end
	end

	// Message bytes: payload, then freshness least significant byte first, then the 0x80 pad.
	always_comb begin
		logic [4:0] idx;
		logic [4:0] len5;
		logic [1:0] fb;
		len5 = {1'b0, len_s1};
		for (int i = 0; i < tcmac_pkg::BLOCK_BYTES; i++) begin
			idx = 5'(i);
			fb  = 2'(idx - len5);
			if (idx < len5) begin
				msg_blk[127 - 8 * i -: 8] = (i < tcmac_pkg::MAX_PAYLOAD) ?
					payload_s1[63 - 8 * (i % tcmac_pkg::MAX_PAYLOAD) -: 8] : 8'h00;
			end else if (idx < len5 + 5'(tcmac_pkg::TAG_BYTES)) begin
				msg_blk[127 - 8 * i -: 8] = fresh_s1[8 * fb +: 8];
			end else if (idx == len5 + 5'(tcmac_pkg::TAG_BYTES)) begin
				msg_blk[127 - 8 * i -: 8] = 8'h80;
			end else begin
				msg_blk[127 - 8 * i -: 8] = 8'h00;
			end
		end
	end

	tcmac_aes_enc u_msg_enc (
		.plain  (msg_blk ^ k2_q),
		.rk     (rk_q),
		.cipher (tag_blk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid) begin
			computed_mac <= tag_blk[127 -: 32];
			mac_match    <= (tag_blk[127 -: 32] == rmac_s1);
		end
	end

	// A key write must hold off new frames until the derived key material has settled.
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> in_stall ##1 in_stall)
		else $error("frame could be taken before derived keys settled");

	// A frame waiting behind a stalled result must not be overwritten.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !out_free |=> s1_valid && $stable(rmac_s1) && $stable(fresh_s1))
		else $error("waiting frame lost or changed");

	// A taken frame lands in the input register.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> s1_valid)
		else $error("accepted frame did not reach the input register");

	// A frame in the input register with room downstream reaches the result register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_free |=> out_valid)
		else $error("frame dropped before the result register");

endmodule

/* sim/truncated_cmac_authenticator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the truncated AES-128-CMAC frame authenticator.
// Depends on tcmac_pkg (types, register indexes, S-box) and the top level under test.
module truncated_cmac_authenticator_unit_tb;

	typedef struct packed {
		logic [31:0] mac;
		logic        match;
	} verdict_t;

	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  len;
		logic [31:0] fresh;
		logic [31:0] rx_mac;
		logic        typed;
		logic [31:0] typed_mac;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] payload = '0;
	logic [3:0]  payload_len = '0;
	logic [31:0] freshness = '0;
	logic [31:0] received_mac = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] computed_mac;
	logic        mac_match;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic [63:0] key_hi_model;
	logic [63:0] key_lo_model;
	verdict_t    pending_verdicts[$];
	int          mismatches = 0;
	int          frames_sent = 0;
	int          verdicts_seen = 0;
	int          match_hits = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	truncated_cmac_authenticator_unit dut (.*);

	always #1 clk = ~clk;

	initial begin
		#5000000;
		$display("truncated_cmac_authenticator_unit regression: fail");
		$finish;
	end

	function automatic logic [7:0] gmul2(input logic [7:0] v);
		gmul2 = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// Straight AES-128 encryption with the key schedule worked out byte by byte.
	function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
		logic [7:0] w [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] tw [4];
		logic [7:0] f, a0, a1, a2, a3, al;
		logic [127:0] res;
		logic [7:0] rc [10];
		rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
		for (int i = 0; i < 16; i++) w[i] = key[127 - 8 * i -: 8];
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) tw[j] = w[i - 4 + j];
			if (i % 16 == 0) begin
				f = tw[0];
				tw[0] = tcmac_pkg::SBOX[tw[1]] ^ rc[i / 16 - 1];
				tw[1] = tcmac_pkg::SBOX[tw[2]];
				tw[2] = tcmac_pkg::SBOX[tw[3]];
				tw[3] = tcmac_pkg::SBOX[f];
			end
			for (int j = 0; j < 4; j++) w[i + j] = w[i - 16 + j] ^ tw[j];
		end
		for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ w[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[i + 4 * c] = tcmac_pkg::SBOX[s[i + 4 * ((c + i) % 4)]];
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
					al = a0 ^ a1 ^ a2 ^ a3;
					t[4 * c]     = a0 ^ al ^ gmul2(a0 ^ a1);
					t[4 * c + 1] = a1 ^ al ^ gmul2(a1 ^ a2);
					t[4 * c + 2] = a2 ^ al ^ gmul2(a2 ^ a3);
					t[4 * c + 3] = a3 ^ al ^ gmul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[16 * r + i];
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
		aes128 = res;
	endfunction

	function automatic verdict_t authenticate(input logic [63:0] pl, input logic [3:0] len,
			input logic [31:0] fresh, input logic [31:0] rx_mac);
		logic [127:0] key, k2, blk, tag;
		int n, used;
		verdict_t v;
		key = {key_hi_model, key_lo_model};
		k2 = aes128(key, '0);
		for (int d = 0; d < 2; d++) k2 = {k2[126:0], 1'b0} ^ (k2[127] ? 128'h87 : 128'h0);
		used = (len > tcmac_pkg::MAX_PAYLOAD) ? tcmac_pkg::MAX_PAYLOAD : len;
		blk = '0;
		n = 0;
		for (int i = 0; i < used; i++) begin
			blk[127 - 8 * n -: 8] = pl[63 - 8 * i -: 8];
			n++;
		end
		for (int i = 0; i < 4; i++) begin
			blk[127 - 8 * n -: 8] = fresh[8 * i +: 8];
			n++;
		end
		blk[127 - 8 * n -: 8] = 8'h80;
		tag = aes128(key, blk ^ k2);
		v.mac = tag[127:96];
		v.match = (v.mac == rx_mac);
		authenticate = v;
	endfunction

	task automatic send_frame(input logic [63:0] pl, input logic [3:0] len,
			input logic [31:0] fresh, input logic [31:0] rx_mac);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		payload <= pl;
		payload_len <= len;
		freshness <= fresh;
		received_mac <= rx_mac;
		pending_verdicts.push_back(authenticate(pl, len, fresh, rx_mac));
		frames_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_key(input tcmac_pkg::reg_index_t idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == tcmac_pkg::REG_KEY_HIGH) key_hi_model = value;
		else key_lo_model = value;
	endtask

	always @(posedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && out_valid && !out_stall) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer: mac %h", computed_mac);
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (exp_v.match) match_hits++;
				if (computed_mac !== exp_v.mac || mac_match !== exp_v.match) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected mac %h match %b, got mac %h match %b",
							exp_v.mac, exp_v.match, computed_mac, mac_match);
				end
			end
		end
	end

	initial begin
		frame_row_t rows [$];
		verdict_t v;
		logic [63:0] pl;
		logic [31:0] fr;
		int unsigned len;
		key_hi_model = tcmac_pkg::KEY_HIGH_RESET;
		key_lo_model = tcmac_pkg::KEY_LOW_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: length extremes, saturated lengths, ignored bytes, field extremes.
		rows.push_back('{64'h0, 4'd0, 32'h0, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0});
		rows.push_back('{64'h0011_2233_4455_6677, 4'd8, 32'h0000_0001, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'h0011_2233_4455_6677, 4'd9, 32'h0000_0001, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'h0011_2233_4455_6677, 4'd15, 32'h0000_0001, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'hAA00_0000_0000_0000, 4'd1, 32'h8000_0000, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'hAAFF_FFFF_FFFF_FFFF, 4'd1, 32'h8000_0000, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'h1234_5678_9ABC_DEF0, 4'd4, 32'hDEAD_BEEF, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'h1234_5678_0000_0000, 4'd4, 32'hDEAD_BEEF, 32'h0, 1'b0, 32'h0});
		rows.push_back('{64'h5555_5555_5555_5555, 4'd7, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0});
		for (int i = 0; i < 9; i++)
			rows.push_back('{64'hF0E1_D2C3_B4A5_9687, 4'(i), 32'h0102_0304, 32'h0, 1'b0, 32'h0});
		foreach (rows[i]) begin
			// For every third row the right MAC is typed in from the predictor so the match flag is driven high too.
			v = authenticate(rows[i].payload, rows[i].len, rows[i].fresh, 32'h0);
			if (i % 3 == 0) rows[i].rx_mac = v.mac;
			send_frame(rows[i].payload, rows[i].len, rows[i].fresh, rows[i].rx_mac);
		end
		drain();

		// Key extremes and one fixed key, each followed by a short burst; the last sets a random key.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_key(tcmac_pkg::REG_KEY_HIGH, '0);
					write_key(tcmac_pkg::REG_KEY_LOW, '0);
				end
				1: begin
					write_key(tcmac_pkg::REG_KEY_HIGH, '1);
					write_key(tcmac_pkg::REG_KEY_LOW, '1);
				end
				2: begin
					write_key(tcmac_pkg::REG_KEY_HIGH, 64'h2B7E_1516_28AE_D2A6);
					write_key(tcmac_pkg::REG_KEY_LOW, 64'hABF7_1588_09CF_4F3C);
				end
				default: begin
					write_key(tcmac_pkg::REG_KEY_HIGH, {$urandom, $urandom});
					write_key(tcmac_pkg::REG_KEY_LOW, {$urandom, $urandom});
				end
			endcase
			for (int k = 0; k < 6; k++)
				send_frame({$urandom, $urandom}, 4'($urandom_range(15)), $urandom, $urandom);
			drain();
		end

		// Random frames under the idling phases, a new key now and then.
		for (int n = 0; n < 400; n++) begin
			if (n % 100 == 0) begin
				drain();
				case (n / 100)
					0: begin send_idle_pct = 0; recv_stall_pct = 0; end
					1: begin send_idle_pct = 68; recv_stall_pct = 0; end
					2: begin send_idle_pct = 0; recv_stall_pct = 68; end
					default: begin send_idle_pct = 11; recv_stall_pct = 11; end
				endcase
				write_key(tcmac_pkg::REG_KEY_HIGH, {$urandom, $urandom});
				write_key(tcmac_pkg::REG_KEY_LOW, {$urandom, $urandom});
			end
			pl = {$urandom, $urandom};
			fr = $urandom;
			len = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
			v = authenticate(pl, 4'(len), fr, 32'h0);
			send_frame(pl, 4'(len), fr, ($urandom_range(3) == 0) ? v.mac : $urandom);
		end
		drain();

		$display("covered %0d frames (%0d with a matching MAC) over nine keys and four idle mixes",
			frames_sent, match_hits);
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("truncated_cmac_authenticator_unit regression: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				pending_verdicts.size());
			$display("truncated_cmac_authenticator_unit regression: fail");
		end
		$finish;
	end
endmodule
